[design/c2s_pkg.sv]
package c2s_pkg;

    // fixed-point fraction bits; 1.0 is 2**FRAC_BITS
    localparam int FRAC_BITS = 16;

    localparam int IW  = 24;                  // cube coordinate width
    localparam int OW  = 25;                  // sphere coordinate width
    localparam int MW  = 23;                  // half size / magnitude width
    localparam int QW  = FRAC_BITS + 1;       // unit value 0..1.0
    localparam int NW  = MW + FRAC_BITS + 1;  // scaling dividend
    localparam int RNW = 2 * FRAC_BITS + 4;   // radicand numerator
    localparam int YW  = FRAC_BITS + 4;       // radicand numerator >> FRAC_BITS
    localparam int SH  = FRAC_BITS + 7;       // reciprocal shift for divide by 6
    localparam int KW  = FRAC_BITS + 5;       // reciprocal width
    localparam int SQW = 2 * FRAC_BITS + 2;   // square root remainder width
    localparam int MHW = QW + MW;             // m * half
    localparam int OMW = MHW - FRAC_BITS + 2; // unsaturated output magnitude

    localparam logic [KW-1:0] RECIP6 = KW'(((64'd1 << SH) + 64'd5) / 64'd6);
    localparam logic [OW-1:0] OUT_MAX = 25'd16777214;
    localparam logic [MW-1:0] HALF_RESET = 23'd1024;

    // pipeline depth: clamp, dividend, divider, 5 radicand, root, 5 tail
    localparam int NST = 2 * QW + 12;

    typedef logic [QW-1:0] t_frac;

    // per-lane side data carried along the pipe
    typedef struct packed {
        logic  neg;
        t_frac u;
    } t_side;

endpackage

[design/cube_to_sphere_map.sv]
// Cube-to-sphere point mapper. Each transfer on the input channel carries one
// cube-surface point (cube_x, cube_y, cube_z); coordinates are scaled to the
// unit cube by the configured planet half size, mapped with
// x' = x*sqrt(1 - y^2/2 - z^2/2 + y^2 z^2/3) (and likewise for y, z), then
// scaled by the planet size (2 * half), rounded to nearest and saturated.
// Coordinates beyond the cube are clamped to it; a half size of zero acts as
// one. The pipeline accepts one point per clock while the output is not
// stalled and is 2*(FRAC_BITS+1)+12 register stages deep (46 at 16 fraction
// bits). That depth is set by the bit-per-stage scaling divider and the
// bit-per-stage square root, each FRAC_BITS+1 stages long. A stall on the
// output holds the whole pipe.
// The half size register is written through the cfg channel (always ready)
// and must only be written while no points are in flight.
module cube_to_sphere_map (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [c2s_pkg::MW-1:0]       i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [c2s_pkg::IW-1:0] i_cube_x,
    input  logic signed [c2s_pkg::IW-1:0] i_cube_y,
    input  logic signed [c2s_pkg::IW-1:0] i_cube_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [c2s_pkg::OW-1:0] o_sphere_x,
    output logic signed [c2s_pkg::OW-1:0] o_sphere_y,
    output logic signed [c2s_pkg::OW-1:0] o_sphere_z
);

    localparam int F   = c2s_pkg::FRAC_BITS;
    localparam int QW  = c2s_pkg::QW;
    localparam int MW  = c2s_pkg::MW;
    localparam int NW  = c2s_pkg::NW;
    localparam int IW  = c2s_pkg::IW;
    localparam int OW  = c2s_pkg::OW;
    localparam int RNW = c2s_pkg::RNW;
    localparam int YW  = c2s_pkg::YW;
    localparam int KW  = c2s_pkg::KW;
    localparam int SH  = c2s_pkg::SH;
    localparam int SQW = c2s_pkg::SQW;
    localparam int MHW = c2s_pkg::MHW;
    localparam int OMW = c2s_pkg::OMW;
    localparam int NST = c2s_pkg::NST;

    // ---------------- configuration ----------------
    logic [MW-1:0] r_half;
    logic [MW-1:0] half_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= c2s_pkg::HALF_RESET;
        end else if (i_cfg_valid) begin
            r_half <= i_cfg_data;
        end
    end

    assign half_eff = (r_half == '0) ? MW'(1) : r_half;

    // ---------------- flow control ----------------
    // whole pipe advances unless the finished result is held
    logic           en;
    logic [NST-1:0] r_vld;

    assign en      = !r_vld[NST-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // ---------------- pipeline registers ----------------
    logic [IW-1:0]       cube [3];
    logic [MW-1:0]       r_0_mag [3];
    logic                r_0_neg [3];
    logic [NW-1:0]       r_1_rem [3];
    logic                r_1_neg [3];

    // scaling divider, one quotient bit per stage
    logic [NW-1:0]       r_dv_rem [QW][3];
    c2s_pkg::t_frac      r_dv_q   [QW][3];
    logic                r_dv_neg [QW][3];
    logic [NW-1:0]       n_dv_rem [QW][3];
    c2s_pkg::t_frac      n_dv_q   [QW][3];
    logic                n_dv_neg [QW][3];

    logic [2*QW-1:0]     r_a_p    [3];
    c2s_pkg::t_side      r_a_sd   [3];
    c2s_pkg::t_frac      r_b_u2   [3];
    c2s_pkg::t_side      r_b_sd   [3];
    logic [2*QW-1:0]     r_c_prod [3];
    logic [QW:0]         r_c_sum  [3];
    c2s_pkg::t_side      r_c_sd   [3];
    logic [YW-1:0]       r_d_y    [3];
    c2s_pkg::t_side      r_d_sd   [3];
    logic [YW+KW-1:0]    r_e_q    [3];
    c2s_pkg::t_side      r_e_sd   [3];

    // square root, one result bit per stage
    logic [SQW-1:0]      r_sq_rem [QW][3];
    logic [SQW-1:0]      r_sq_res [QW][3];
    c2s_pkg::t_side      r_sq_sd  [QW][3];
    logic [SQW-1:0]      n_sq_rem [QW][3];
    logic [SQW-1:0]      n_sq_res [QW][3];
    c2s_pkg::t_side      n_sq_sd  [QW][3];

    c2s_pkg::t_frac      r_g_s   [3];
    c2s_pkg::t_side      r_g_sd  [3];
    logic [2*QW-1:0]     r_h_um  [3];
    logic                r_h_neg [3];
    c2s_pkg::t_frac      r_i_m   [3];
    logic                r_i_neg [3];
    logic [MHW-1:0]      r_j_mh  [3];
    logic                r_j_neg [3];
    logic [OW-1:0]       r_out   [3];

    assign cube[0] = i_cube_x;
    assign cube[1] = i_cube_y;
    assign cube[2] = i_cube_z;

    // divider next state
    always_comb begin
        logic [NW-1:0] rem;
        logic [NW:0]   dsh;
        c2s_pkg::t_frac q;
        logic          ng;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    rem = r_1_rem[l];
                    q   = '0;
                    ng  = r_1_neg[l];
                end else begin
                    rem = r_dv_rem[k-1][l];
                    q   = r_dv_q[k-1][l];
                    ng  = r_dv_neg[k-1][l];
                end
                dsh = (NW+1)'(half_eff) << (QW - 1 - k);
                if ({1'b0, rem} >= dsh) begin
                    rem = NW'({1'b0, rem} - dsh);
                    q[QW-1-k] = 1'b1;
                end
                n_dv_rem[k][l] = rem;
                n_dv_q[k][l]   = q;
                n_dv_neg[k][l] = ng;
            end
        end
    end

    // square root next state
    always_comb begin
        logic [SQW-1:0] rem;
        logic [SQW-1:0] res;
        logic [SQW-1:0] bt;
        logic [SQW-1:0] t;
        c2s_pkg::t_side sd;
        for (int j = 0; j < QW; j++) begin
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    rem = SQW'(r_e_q[l][SH+QW-1:SH]) << F;
                    res = '0;
                    sd  = r_e_sd[l];
                end else begin
                    rem = r_sq_rem[j-1][l];
                    res = r_sq_res[j-1][l];
                    sd  = r_sq_sd[j-1][l];
                end
                bt = SQW'(1) << (2 * (F - j));
                t  = res + bt;
                if (rem >= t) begin
                    rem = rem - t;
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                n_sq_rem[j][l] = rem;
                n_sq_res[j][l] = res;
                n_sq_sd[j][l]  = sd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [IW-1:0]     av;
        logic [2*QW-1:0]   bsum;
        logic [RNW-1:0]    num;
        logic [MHW:0]      osum;
        logic [OMW-1:0]    omag;
        logic [OW-1:0]     mo;
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                // clamp magnitude to the cube
                r_0_neg[l] <= cube[l][IW-1];
                av = cube[l][IW-1] ? (~cube[l] + IW'(1)) : cube[l];
                r_0_mag[l] <= (av > IW'(half_eff)) ? half_eff : av[MW-1:0];

                // rounded dividend mag * 1.0 + half / 2
                r_1_rem[l] <= (NW'(r_0_mag[l]) << F) + NW'(half_eff >> 1);
                r_1_neg[l] <= r_0_neg[l];

                // u squared
                r_a_p[l]      <= (2*QW)'(r_dv_q[QW-1][l]) * (2*QW)'(r_dv_q[QW-1][l]);
                r_a_sd[l].u   <= r_dv_q[QW-1][l];
                r_a_sd[l].neg <= r_dv_neg[QW-1][l];

                bsum = r_a_p[l] + (2*QW)'(1 << (F - 1));
                r_b_u2[l] <= bsum[F+QW-1:F];
                r_b_sd[l] <= r_a_sd[l];

                // product and sum of the two other lanes
                r_c_prod[l] <= (2*QW)'(r_b_u2[(l+1)%3]) * (2*QW)'(r_b_u2[(l+2)%3]);
                r_c_sum[l]  <= (QW+1)'(r_b_u2[(l+1)%3]) + (QW+1)'(r_b_u2[(l+2)%3]);
                r_c_sd[l]   <= r_b_sd[l];

                // 6 - 3a - 3b + 2ab, plus 3 for rounding the divide by 6
                num = (RNW'(6) << (2 * F)) + (RNW'(r_c_prod[l]) << 1)
                    + (RNW'(3) << F) - ((RNW'(r_c_sum[l]) * RNW'(3)) << F);
                r_d_y[l]  <= num[RNW-1:F];
                r_d_sd[l] <= r_c_sd[l];

                // divide by 6 through reciprocal
                r_e_q[l]  <= (YW+KW)'(r_d_y[l]) * (YW+KW)'(c2s_pkg::RECIP6);
                r_e_sd[l] <= r_d_sd[l];

                // round the root
                r_g_s[l]  <= r_sq_res[QW-1][l][QW-1:0]
                           + QW'(r_sq_rem[QW-1][l] > r_sq_res[QW-1][l]);
                r_g_sd[l] <= r_sq_sd[QW-1][l];

                r_h_um[l]  <= (2*QW)'(r_g_sd[l].u) * (2*QW)'(r_g_s[l]);
                r_h_neg[l] <= r_g_sd[l].neg;

                bsum = r_h_um[l] + (2*QW)'(1 << (F - 1));
                r_i_m[l]   <= bsum[F+QW-1:F];
                r_i_neg[l] <= r_h_neg[l];

                r_j_mh[l]  <= MHW'(r_i_m[l]) * MHW'(half_eff);
                r_j_neg[l] <= r_i_neg[l];

                // times 2 * half, rounded, saturated, sign restored
                osum = (MHW+1)'(r_j_mh[l]) + (MHW+1)'(1 << (F - 2));
                omag = osum[MHW:F-1];
                mo   = (omag > OMW'(c2s_pkg::OUT_MAX)) ? c2s_pkg::OUT_MAX : omag[OW-1:0];
                r_out[l] <= (r_j_neg[l] && mo != '0) ? (~mo + OW'(1)) : mo;
            end
            r_dv_rem <= n_dv_rem;
            r_dv_q   <= n_dv_q;
            r_dv_neg <= n_dv_neg;
            r_sq_rem <= n_sq_rem;
            r_sq_res <= n_sq_res;
            r_sq_sd  <= n_sq_sd;
        end
    end

    assign o_sphere_x = r_out[0];
    assign o_sphere_y = r_out[1];
    assign o_sphere_z = r_out[2];

endmodule

[design/c2s_checker.sv]
module c2s_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [c2s_pkg::OW-1:0] o_sphere_x,
    input logic signed [c2s_pkg::OW-1:0] o_sphere_y,
    input logic signed [c2s_pkg::OW-1:0] o_sphere_z
);

    localparam logic signed [c2s_pkg::OW-1:0] MAXV = c2s_pkg::OUT_MAX;
    localparam logic signed [c2s_pkg::OW-1:0] MINV = -c2s_pkg::OUT_MAX;

    // held result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_sphere_x) && $stable(o_sphere_y)
                              && $stable(o_sphere_z)) else $error("result changed under stall");

    // input side stalls exactly when the output is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall)) else $error("stall not tied to output hold");

    // results stay within the saturation range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sphere_x <= MAXV && o_sphere_x >= MINV
                 && o_sphere_y <= MAXV && o_sphere_y >= MINV
                 && o_sphere_z <= MAXV && o_sphere_z >= MINV)
        else $error("result out of range");

endmodule

bind cube_to_sphere_map c2s_checker u_c2s_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_sphere_x (o_sphere_x),
    .o_sphere_y (o_sphere_y),
    .o_sphere_z (o_sphere_z)
);
